@@ hw/rtl/hid_report_to_ps2_set2_scancodes_defines.svh @@
// assertion macros shared by the scan code translator modules
// no dependencies; define NO_ASSERTIONS to drop all checks
`ifndef HID_REPORT_TO_PS2_SET2_SCANCODES_DEFINES_SVH
`define HID_REPORT_TO_PS2_SET2_SCANCODES_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/hps2_pkg.sv @@
// types, constants and scan code rom for the hid to ps/2 translator
// no dependencies
package hps2_pkg;
    localparam int NUM_SLOTS  = 4;
    localparam int RING_DEPTH = 64;
    localparam int SLOT_W     = 2;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int SEL_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int NKEYS      = 6;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    localparam logic [7:0] MARK_AA      = 8'hAA;
    localparam logic [7:0] PREFIX_EXT   = 8'hE0;
    localparam logic [7:0] PREFIX_BREAK = 8'hF0;
    localparam logic [7:0] ROLLOVER     = 8'h01;
    localparam logic [7:0] MOD_BASE     = 8'hE0;
    localparam logic [7:0] ROM_SIZE     = 8'hE8;

    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_POLL   = 1'b1;

    // input word
    typedef struct packed {
        logic        kind;
        logic [1:0]  slot;
        logic [7:0]  modifiers;
        logic [7:0]  key_a;
        logic [7:0]  key_b;
        logic [7:0]  key_c;
        logic [7:0]  key_d;
        logic [7:0]  key_e;
        logic [7:0]  key_f;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_slot;
    } t_out_word;

    // queue entry: one classified code to push, or a poll
    typedef struct packed {
        logic             poll;
        logic [SEL_W-1:0] slot;
        logic             in_range;
        logic             mark;      // push 0xAA
        logic             release_k;
        logic [7:0]       usage;
    } t_cmd;

    // rom: bit 8 = extended, low byte = code, 0 = unmapped
    function automatic logic [8:0] scan_rom(input logic [7:0] u);
        logic [8:0] r;
        begin
            unique case (u)
                8'h04: r = 9'h01C; 8'h05: r = 9'h032; 8'h06: r = 9'h021; 8'h07: r = 9'h023;
                8'h08: r = 9'h024; 8'h09: r = 9'h02B; 8'h0A: r = 9'h034; 8'h0B: r = 9'h033;
                8'h0C: r = 9'h043; 8'h0D: r = 9'h03B; 8'h0E: r = 9'h042; 8'h0F: r = 9'h04B;
                8'h10: r = 9'h03A; 8'h11: r = 9'h031; 8'h12: r = 9'h044; 8'h13: r = 9'h04D;
                8'h14: r = 9'h015; 8'h15: r = 9'h02D; 8'h16: r = 9'h01B; 8'h17: r = 9'h02C;
                8'h18: r = 9'h03C; 8'h19: r = 9'h02A; 8'h1A: r = 9'h01D; 8'h1B: r = 9'h022;
                8'h1C: r = 9'h035; 8'h1D: r = 9'h01A; 8'h1E: r = 9'h016; 8'h1F: r = 9'h01E;
                8'h20: r = 9'h026; 8'h21: r = 9'h025; 8'h22: r = 9'h02E; 8'h23: r = 9'h036;
                8'h24: r = 9'h03D; 8'h25: r = 9'h03E; 8'h26: r = 9'h046; 8'h27: r = 9'h045;
                8'h28: r = 9'h05A; 8'h29: r = 9'h076; 8'h2A: r = 9'h066; 8'h2B: r = 9'h00D;
                8'h2C: r = 9'h029; 8'h2D: r = 9'h04E; 8'h2E: r = 9'h055; 8'h2F: r = 9'h054;
                8'h30: r = 9'h05B; 8'h31: r = 9'h05D; 8'h33: r = 9'h04C; 8'h34: r = 9'h052;
                8'h35: r = 9'h00E; 8'h36: r = 9'h041; 8'h37: r = 9'h049; 8'h38: r = 9'h04A;
                8'h39: r = 9'h058; 8'h3A: r = 9'h005; 8'h3B: r = 9'h006; 8'h3C: r = 9'h004;
                8'h3D: r = 9'h00C; 8'h3E: r = 9'h003; 8'h3F: r = 9'h00B; 8'h40: r = 9'h083;
                8'h41: r = 9'h00A; 8'h42: r = 9'h001; 8'h43: r = 9'h009; 8'h44: r = 9'h078;
                8'h45: r = 9'h007; 8'h47: r = 9'h07E;
                8'h49: r = 9'h170; 8'h4A: r = 9'h16C; 8'h4B: r = 9'h17D; 8'h4C: r = 9'h171;
                8'h4D: r = 9'h169; 8'h4E: r = 9'h17A; 8'h4F: r = 9'h174; 8'h50: r = 9'h16B;
                8'h51: r = 9'h172; 8'h52: r = 9'h175; 8'h53: r = 9'h077; 8'h54: r = 9'h14A;
                8'h55: r = 9'h07C; 8'h56: r = 9'h07B; 8'h57: r = 9'h079; 8'h58: r = 9'h15A;
                8'h59: r = 9'h069; 8'h5A: r = 9'h072; 8'h5B: r = 9'h07A; 8'h5C: r = 9'h06B;
                8'h5D: r = 9'h073; 8'h5E: r = 9'h074; 8'h5F: r = 9'h06C; 8'h60: r = 9'h075;
                8'h61: r = 9'h07D; 8'h62: r = 9'h070; 8'h63: r = 9'h071;
                8'hE0: r = 9'h014; 8'hE1: r = 9'h012; 8'hE2: r = 9'h011; 8'hE3: r = 9'h11F;
                8'hE4: r = 9'h114; 8'hE5: r = 9'h059; 8'hE6: r = 9'h111; 8'hE7: r = 9'h127;
                default: r = 9'h000;
            endcase
            return r;
        end
    endfunction
endpackage

@@ hw/rtl/hps2_if.sv @@
// valid/ready channel carrying one word of type T
// no dependencies
interface hps2_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hw/rtl/hps2_front.sv @@
// front end: diffs each report against the slot's previous one, emits commands
// depends on hps2_pkg and the defines header
`include "hid_report_to_ps2_set2_scancodes_defines.svh"
module hps2_front import hps2_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_in_word   i_in_data,
    output logic       o_cmd_valid,
    input  logic       i_cmd_ready,
    output t_cmd       o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_MARK, S_MODS, S_NEW, S_OLD, S_DONE} t_state;

    t_state              r_state;
    logic [SEL_W-1:0]    r_slot;
    logic [7:0]          r_mods;
    logic [7:0]          r_oldmods;
    logic [7:0]          r_cur [NKEYS];
    logic [7:0]          r_old [NKEYS];
    logic [2:0]          r_idx;
    logic [7:0]          r_slot_mods [NUM_SLOTS];
    logic [7:0]          r_slot_keys [NUM_SLOTS][NKEYS];
    logic [NUM_SLOTS-1:0] r_started;

    logic [7:0] w_keys [NKEYS];
    logic       w_roll;
    logic       w_in_range;
    logic [SEL_W-1:0] w_sel;
    logic       w_fire;
    logic       w_emit;
    logic [7:0] w_usage;
    logic       w_rel;
    logic       w_in_old;
    logic       w_in_cur;
    logic [7:0] w_mbit;
    logic       w_cmd_set;

    assign w_keys[0] = i_in_data.key_a;
    assign w_keys[1] = i_in_data.key_b;
    assign w_keys[2] = i_in_data.key_c;
    assign w_keys[3] = i_in_data.key_d;
    assign w_keys[4] = i_in_data.key_e;
    assign w_keys[5] = i_in_data.key_f;
    assign w_sel      = i_in_data.slot[SEL_W-1:0];
    assign w_in_range = ({30'd0, i_in_data.slot} < NUM_SLOTS);

    // rollover detection
    always_comb begin
        w_roll = 1'b1;
        for (int i = 0; i < NKEYS; i++)
            if (w_keys[i] != ROLLOVER) w_roll = 1'b0;
    end

    assign o_in_ready = (r_state == S_IDLE) && (!o_cmd_valid || i_cmd_ready);
    assign w_fire     = i_in_valid && o_in_ready;

    // membership of the current element
    always_comb begin
        w_in_old = 1'b0;
        w_in_cur = 1'b0;
        for (int i = 0; i < NKEYS; i++) begin
            if (r_old[i] == r_cur[r_idx]) w_in_old = 1'b1;
            if (r_cur[i] == r_old[r_idx]) w_in_cur = 1'b1;
        end
    end
    assign w_mbit = 8'd1 << r_idx;

    // what this cycle would emit while stepping
    always_comb begin
        w_emit  = 1'b0;
        w_usage = 8'd0;
        w_rel   = 1'b0;
        unique case (r_state)
            S_MARK: w_emit = 1'b1;
            S_MODS: begin
                w_emit  = ((r_mods ^ r_oldmods) & w_mbit) != 8'd0;
                w_usage = MOD_BASE + {5'd0, r_idx};
                w_rel   = (r_mods & w_mbit) == 8'd0;
            end
            S_NEW: begin
                w_emit  = (r_cur[r_idx] != 8'd0) && !w_in_old;
                w_usage = r_cur[r_idx];
            end
            S_OLD: begin
                w_emit  = (r_old[r_idx] != 8'd0) && !w_in_cur;
                w_usage = r_old[r_idx];
                w_rel   = 1'b1;
            end
            default: w_emit = 1'b0;
        endcase
    end

    // a new command word is loaded this cycle
    assign w_cmd_set = (w_fire && i_in_data.kind == KIND_POLL)
                     || (w_emit && (!o_cmd_valid || i_cmd_ready));

    // sequencer and registered command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_cmd_valid <= 1'b0;
            r_started   <= '0;
            r_idx       <= 3'd0;
        end else begin
            if (i_cmd_ready && !w_cmd_set) o_cmd_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (w_fire) begin
                    r_slot <= w_sel;
                    r_mods <= i_in_data.modifiers;
                    for (int i = 0; i < NKEYS; i++) r_cur[i] <= w_keys[i];
                    r_idx  <= 3'd0;
                    if (i_in_data.kind == KIND_POLL) begin
                        o_cmd_valid      <= 1'b1;
                        o_cmd.poll       <= 1'b1;
                        o_cmd.slot       <= w_sel;
                        o_cmd.in_range   <= w_in_range;
                        o_cmd.mark       <= 1'b0;
                        o_cmd.release_k  <= 1'b0;
                        o_cmd.usage      <= 8'd0;
                    end else if (w_in_range && !w_roll) begin
                        if (!r_started[w_sel]) begin
                            r_oldmods <= 8'd0;
                            for (int i = 0; i < NKEYS; i++) r_old[i] <= 8'd0;
                            r_started[w_sel] <= 1'b1;
                            r_state <= S_MARK;
                        end else begin
                            r_oldmods <= r_slot_mods[w_sel];
                            for (int i = 0; i < NKEYS; i++)
                                r_old[i] <= r_slot_keys[w_sel][i];
                            r_state <= S_MODS;
                        end
                    end
                end
                S_DONE: begin
                    r_slot_mods[r_slot] <= r_mods;
                    for (int i = 0; i < NKEYS; i++) r_slot_keys[r_slot][i] <= r_cur[i];
                    r_state <= S_IDLE;
                end
                default: if (!w_emit || !o_cmd_valid || i_cmd_ready) begin
                    if (w_emit) begin
                        o_cmd_valid     <= 1'b1;
                        o_cmd.poll      <= 1'b0;
                        o_cmd.slot      <= r_slot;
                        o_cmd.in_range  <= 1'b1;
                        o_cmd.mark      <= (r_state == S_MARK);
                        o_cmd.release_k <= w_rel;
                        o_cmd.usage     <= w_usage;
                    end
                    priority if (r_state == S_MARK) begin
                        r_state <= S_MODS;
                        r_idx   <= 3'd0;
                    end else if (r_state == S_MODS && r_idx == 3'd7) begin
                        r_state <= S_NEW;
                        r_idx   <= 3'd0;
                    end else if (r_state == S_NEW && r_idx == 3'(NKEYS - 1)) begin
                        r_state <= S_OLD;
                        r_idx   <= 3'd0;
                    end else if (r_state == S_OLD && r_idx == 3'(NKEYS - 1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + 3'd1;
                    end
                end
            endcase
        end
    end

    `ASSERT_IMPL(a_ready_idle, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE,
        "front ready outside idle")
    `ASSERT_IMPL(a_idx_range, i_clk, i_rst_n, r_state == S_NEW || r_state == S_OLD,
        r_idx < 3'(NKEYS), "key index out of range")
    `ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, r_state == S_DONE, r_state == S_IDLE,
        "done not followed by idle")
endmodule

@@ hw/rtl/hps2_cmd_fifo.sv @@
// short queue of commands between front and back end
// depends on hps2_pkg and the defines header
`include "hid_report_to_ps2_set2_scancodes_defines.svh"
module hps2_cmd_fifo import hps2_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr_valid,
    output logic  o_wr_ready,
    input  t_cmd  i_wr_data,
    output logic  o_rd_valid,
    input  logic  i_rd_ready,
    output t_cmd  o_rd_data
);
    t_cmd            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic w_wr;
    logic w_rd;

    assign o_wr_ready = r_cnt != (QPTR_W+1)'(QDEPTH);
    assign o_rd_valid = r_cnt != '0;
    assign o_rd_data  = r_mem[r_rp];
    assign w_wr = i_wr_valid && o_wr_ready;
    assign w_rd = o_rd_valid && i_rd_ready;

    // pointers and storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_mem[r_wp] <= i_wr_data;
                r_wp        <= r_wp + 1'b1;
            end
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPTR_W+1)'(w_wr) - (QPTR_W+1)'(w_rd);
        end
    end

    `ASSERT_IMPL(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= (QPTR_W+1)'(QDEPTH),
        "queue count overflow")
    `ASSERT_NEXT(a_cnt_up, i_clk, i_rst_n, w_wr && !w_rd, r_cnt == $past(r_cnt) + 1'b1,
        "queue count did not advance")
endmodule

@@ hw/rtl/hps2_back.sv @@
// back end: expands commands into ring bytes and serves polls
// depends on hps2_pkg and the defines header
`include "hid_report_to_ps2_set2_scancodes_defines.svh"
module hps2_back import hps2_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output t_out_word  o_out_data
);
    typedef enum logic [2:0] {B_IDLE, B_EXT, B_BRK, B_CODE, B_READ, B_ANS} t_state;

    t_state          r_state;
    logic [7:0]      r_ring [NUM_SLOTS*RING_DEPTH];
    logic [PTR_W-1:0] r_head [NUM_SLOTS];
    logic [PTR_W-1:0] r_tail [NUM_SLOTS];
    logic [7:0]      r_last [NUM_SLOTS];
    t_cmd            r_cmd;
    logic [8:0]      r_enc;
    logic [7:0]      r_peek;

    logic [8:0]      w_enc;
    logic            w_take;
    logic [7:0]      w_byte;
    logic            w_push;
    logic [PTR_W-1:0] w_tail;
    logic [PTR_W-1:0] w_nxt;
    logic            w_empty;
    logic [7:0]      w_ans;

    assign w_enc  = (i_cmd.usage < ROM_SIZE) ? scan_rom(i_cmd.usage) : 9'd0;
    assign o_cmd_ready = (r_state == B_IDLE);
    assign w_take = i_cmd_valid && o_cmd_ready;
    assign w_tail = r_tail[r_cmd.slot];
    assign w_nxt  = w_tail + 1'b1;
    assign w_empty = r_head[r_cmd.slot] == w_tail;

    // byte pushed this cycle
    always_comb begin
        w_push = 1'b0;
        w_byte = r_enc[7:0];
        unique case (r_state)
            B_EXT:  begin w_push = 1'b1; w_byte = PREFIX_EXT; end
            B_BRK:  begin w_push = 1'b1; w_byte = PREFIX_BREAK; end
            B_CODE: begin w_push = 1'b1; w_byte = r_cmd.mark ? MARK_AA : r_enc[7:0]; end
            default: w_push = 1'b0;
        endcase
    end

    // poll answer
    always_comb begin
        w_ans = 8'd0;
        if (r_cmd.in_range && !w_empty && !(r_peek == r_last[r_cmd.slot] && r_peek != 8'd0))
            w_ans = r_peek;
    end

    // ring memory, read registered
    always_ff @(posedge i_clk) begin
        if (w_push && w_nxt != r_head[r_cmd.slot])
            r_ring[{r_cmd.slot, w_tail}] <= w_byte;
        r_peek <= r_ring[{r_cmd.slot, r_head[r_cmd.slot]}];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            o_out_valid <= 1'b0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_last[i] <= 8'd0;
            end
        end else begin
            if (o_out_valid && i_out_ready && r_state != B_ANS) o_out_valid <= 1'b0;
            if (w_push && w_nxt != r_head[r_cmd.slot]) r_tail[r_cmd.slot] <= w_nxt;
            unique case (r_state)
                B_IDLE: if (w_take) begin
                    r_cmd <= i_cmd;
                    r_enc <= w_enc;
                    priority if (i_cmd.poll) r_state <= B_READ;
                    else if (i_cmd.mark) r_state <= B_CODE;
                    else if (w_enc == 9'd0) r_state <= B_IDLE;
                    else if (w_enc[8]) r_state <= B_EXT;
                    else if (i_cmd.release_k) r_state <= B_BRK;
                    else r_state <= B_CODE;
                end
                B_EXT:  r_state <= r_cmd.release_k ? B_BRK : B_CODE;
                B_BRK:  r_state <= B_CODE;
                B_CODE: r_state <= B_IDLE;
                B_READ: r_state <= B_ANS;
                B_ANS: if (!o_out_valid || i_out_ready) begin
                    o_out_valid         <= 1'b1;
                    o_out_data.out_byte <= w_ans;
                    o_out_data.out_slot <= r_cmd.slot[SLOT_W-1:0];
                    if (r_cmd.in_range) begin
                        r_last[r_cmd.slot] <= w_ans;
                        if (w_ans != 8'd0) r_head[r_cmd.slot] <= r_head[r_cmd.slot] + 1'b1;
                    end
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_ans_range, i_clk, i_rst_n, o_out_valid && !$stable(o_out_data),
        $past(r_state) == B_ANS, "result changed outside answer state")
    `ASSERT_NEXT(a_ext_next, i_clk, i_rst_n, r_state == B_EXT,
        r_state == B_BRK || r_state == B_CODE, "prefix not followed by code")
    `ASSERT_IMPL(a_brk_rel, i_clk, i_rst_n, r_state == B_BRK, r_cmd.release_k,
        "break prefix on a make")
endmodule

@@ hw/rtl/hid_report_to_ps2_set2_scancodes.sv @@
// HID boot keyboard report to PS/2 set 2 translator with four keyboard slots.
// A report is accepted in the idle state and then stepped through the front
// sequencer (one step per modifier bit and per key compare), while the back end
// takes each queued command in its idle state and then pushes one byte per cycle
// into the ring memory; a poll reads the ring head registered and is answered
// from the answer state, which waits while the output is not ready. No reset
// clearing pass.
// depends on hps2_pkg, hps2_if, hps2_front, hps2_cmd_fifo, hps2_back
module hid_report_to_ps2_set2_scancodes import hps2_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    hps2_if.sink   i_in,
    hps2_if.source o_out
);
    logic f_valid, f_ready, q_valid, q_ready;
    t_cmd f_cmd, q_cmd;

    // front end
    hps2_front u_front (
        .i_clk, .i_rst_n,
        .i_in_valid(i_in.valid), .o_in_ready(i_in.ready), .i_in_data(i_in.data),
        .o_cmd_valid(f_valid), .i_cmd_ready(f_ready), .o_cmd(f_cmd)
    );

    // command queue
    hps2_cmd_fifo u_fifo (
        .i_clk, .i_rst_n,
        .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_data(f_cmd),
        .o_rd_valid(q_valid), .i_rd_ready(q_ready), .o_rd_data(q_cmd)
    );

    // back end
    hps2_back u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(q_valid), .o_cmd_ready(q_ready), .i_cmd(q_cmd),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready), .o_out_data(o_out.data)
    );
endmodule
